>>> src/crc16rfc_pkg.sv
package crc16rfc_pkg;

    localparam int unsigned FRAME_BYTES = 11;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned BYTE_W      = 8;

    // The received CRC occupies the last two bytes of the frame, low byte first.
    localparam logic [POS_W-1:0] CRC_LOW_POS = POS_W'(FRAME_BYTES - 2);

    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

endpackage

>>> src/crc16rfc_crc_byte.sv
module crc16rfc_crc_byte
    import crc16rfc_pkg::*;
(
    input  logic [CRC_W-1:0]  i_crc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [CRC_W-1:0]  o_crc
);

    // Reflected CRC, one shift per data bit, least significant bit first.
    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {{(CRC_W - BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

>>> src/crc16rfc_frame_track.sv
module crc16rfc_frame_track
    import crc16rfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_is_last,
    output logic [CRC_W-1:0]  o_running_crc,
    output logic [CRC_W-1:0]  o_received_crc
);

    logic [POS_W-1:0]  r_pos;
    logic [CRC_W-1:0]  r_crc;
    logic [BYTE_W-1:0] r_crc_low;
    logic [CRC_W-1:0]  n_crc;
    logic              is_payload;
    logic              is_low;

    assign is_payload = r_pos < CRC_LOW_POS;
    assign is_low     = r_pos == CRC_LOW_POS;
    // Any position past the low CRC byte is handled as the end of the frame.
    assign o_is_last  = !is_payload && !is_low;

    assign o_running_crc  = r_crc;
    assign o_received_crc = {i_byte, r_crc_low};

    crc16rfc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (n_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_crc_low <= '0;
        end else if (i_advance) begin
            if (is_payload) begin
                r_crc <= n_crc;
                r_pos <= r_pos + POS_W'(1);
            end else if (is_low) begin
                r_crc_low <= i_byte;
                r_pos     <= r_pos + POS_W'(1);
            end else begin
                r_pos     <= '0;
                r_crc     <= CRC_INIT;
                r_crc_low <= '0;
            end
        end
    end

endmodule

>>> src/crc16_response_frame_checker.sv
// CRC-16/MODBUS check of fixed-length response frames, one received byte per request.
// Input channel: i_in_valid / o_in_ready carry i_rx_byte. Every byte is one request;
// the frame is FRAME_BYTES long, payload first, then the received CRC low and high byte.
// Output channel: o_out_valid / i_out_ready carry o_frame_ok, o_computed_crc and
// o_received_crc, one request per frame, produced by the frame's last byte only.
// Order: a byte taken is held in the input register, and the frame result of a last
// byte is then loaded into the output register, which drives o_out_valid; a last byte
// that waits for the output register stays in the input register (see Stall).
// Throughput: one byte per cycle unless a last byte waits (see Stall); the byte-wide CRC
// update between the input register and the frame state sets the cycle time.
// Stall: payload and CRC-low bytes never wait. A last byte waits in the input register
// while a previous result is still untaken, and o_in_ready drops only in that case.
// Reset (i_rst_n low at a clock edge) empties both registers and restarts frame
// tracking at the first byte with the CRC at its start value. Frames are counted from
// reset; a lost or extra byte shifts every later frame.
module crc16_response_frame_checker
    import crc16rfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_frame_ok,
    output logic [CRC_W-1:0]  o_computed_crc,
    output logic [CRC_W-1:0]  o_received_crc
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic              r_frame_ok;
    logic [CRC_W-1:0]  r_computed_crc;
    logic [CRC_W-1:0]  r_received_crc;

    logic              is_last;
    logic [CRC_W-1:0]  running_crc;
    logic [CRC_W-1:0]  received_crc;
    logic              out_free;
    logic              advance;

    crc16rfc_frame_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_byte         (r_in_byte),
        .o_is_last      (is_last),
        .o_running_crc  (running_crc),
        .o_received_crc (received_crc)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!is_last || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_in_byte  <= i_rx_byte;
            end
            if (advance && is_last) begin
                r_out_valid    <= 1'b1;
                r_frame_ok     <= running_crc == received_crc;
                r_computed_crc <= running_crc;
                r_received_crc <= received_crc;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ok     = r_frame_ok;
    assign o_computed_crc = r_computed_crc;
    assign o_received_crc = r_received_crc;

endmodule

>>> tb/testbench.sv
module testbench;
    import crc16rfc_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [CRC_W-1:0] computed;
        logic [CRC_W-1:0] received;
    } t_frame_result;

    // Follows the frame position and CRC of the byte stream and keeps the frame
    // results that are still owed by the block.
    class t_frame_crc_tracker;
        logic [POS_W-1:0]  byte_pos;
        logic [CRC_W-1:0]  run_crc;
        logic [BYTE_W-1:0] crc_low;
        t_frame_result     pending_frames[$];
        int                mismatch_count;

        function new();
            byte_pos       = '0;
            run_crc        = CRC_INIT;
            crc_low        = '0;
            mismatch_count = 0;
        endfunction

        static function logic [CRC_W-1:0] modbus_crc_byte(logic [CRC_W-1:0] crc,
                                                           logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            t_frame_result r;
            if (byte_pos < CRC_LOW_POS) begin
                run_crc  = modbus_crc_byte(run_crc, b);
                byte_pos = byte_pos + POS_W'(1);
            end else if (byte_pos == CRC_LOW_POS) begin
                crc_low  = b;
                byte_pos = byte_pos + POS_W'(1);
            end else begin
                // Last byte of the frame: the result is owed and the state starts over.
                r.received = {b, crc_low};
                r.computed = run_crc;
                r.ok       = (run_crc == r.received);
                pending_frames.insert(pending_frames.size(), r);
                byte_pos = '0;
                run_crc  = CRC_INIT;
                crc_low  = '0;
            end
        endfunction

        function void check_result(logic ok, logic [CRC_W-1:0] computed,
                                   logic [CRC_W-1:0] received);
            t_frame_result e;
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result ok=%0b computed=%h received=%h",
                         $time, ok, computed, received);
                mismatch_count++;
                return;
            end
            e = pending_frames.pop_front();
            if (ok !== e.ok) begin
                $display("%0t: frame_ok expected %0b, actual %0b", $time, e.ok, ok);
                mismatch_count++;
            end
            if (computed !== e.computed) begin
                $display("%0t: computed_crc expected %h, actual %h",
                         $time, e.computed, computed);
                mismatch_count++;
            end
            if (received !== e.received) begin
                $display("%0t: received_crc expected %h, actual %h",
                         $time, e.received, received);
                mismatch_count++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_frame_ok;
    logic [CRC_W-1:0]  o_computed_crc;
    logic [CRC_W-1:0]  o_received_crc;

    t_frame_crc_tracker tracker;
    logic [BYTE_W-1:0]  frame_buf [FRAME_BYTES];
    int                 bytes_sent;
    bit                 idle_on;
    bit                 drained;
    int                 kind;
    int                 stall_left;

    crc16_response_frame_checker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_ok     (o_frame_ok),
        .o_computed_crc (o_computed_crc),
        .o_received_crc (o_received_crc)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tracker.note_byte(i_rx_byte);
            end
            if (o_out_valid && i_out_ready) begin
                tracker.check_result(o_frame_ok, o_computed_crc, o_received_crc);
            end
        end
    end

    // Result side: ready with random stall bursts while idling is enabled.
    initial begin
        i_out_ready = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0) begin
                    stall_left = $urandom_range(1, 15);
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Writes the correct CRC of the payload into the last two bytes.
    task automatic seal_frame();
        logic [CRC_W-1:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_BYTES - 2; i++) begin
            crc = t_frame_crc_tracker::modbus_crc_byte(crc, frame_buf[i]);
        end
        frame_buf[FRAME_BYTES-2] = crc[7:0];
        frame_buf[FRAME_BYTES-1] = crc[15:8];
    endtask

    task automatic send_frame();
        for (int i = 0; i < FRAME_BYTES; i++) begin
            send_byte(frame_buf[i]);
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending_frames.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = '0;
        idle_on    = 1'b1;
        drained    = 1'b0;
        bytes_sent = 0;
        tracker    = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All-zero payload with its correct CRC, then an all-ones payload whose
        // CRC high byte is damaged.
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        seal_frame();
        send_frame();
        foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
        seal_frame();
        frame_buf[FRAME_BYTES-1] = frame_buf[FRAME_BYTES-1] ^ 8'h80;
        send_frame();

        while (bytes_sent < 850) begin
            if (bytes_sent > 720) begin
                idle_on = 1'b0;
            end else begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                // Loose bytes shift the framing; pad to the next frame boundary so
                // that the well-formed frames after them line up again.
                repeat ($urandom_range(1, 20)) send_byte(BYTE_W'($urandom_range(0, 255)));
                while (bytes_sent % FRAME_BYTES != 0) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end else begin
                foreach (frame_buf[i]) frame_buf[i] = BYTE_W'($urandom_range(0, 255));
                seal_frame();
                if (kind < 5) begin
                    frame_buf[$urandom_range(0, FRAME_BYTES-1)][$urandom_range(0, 7)] ^= 1'b1;
                end
                send_frame();
            end
            if (!drained && bytes_sent > 400) begin
                wait_for_results();
                drained = 1'b1;
            end
        end

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending_frames.size() == 0) begin
            $display("crc16_response_frame_checker: match");
        end else begin
            $display("crc16_response_frame_checker: mismatch");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("crc16_response_frame_checker: mismatch");
        $finish;
    end

endmodule

>>> crc16_response_frame_checker.f
src/crc16rfc_pkg.sv
src/crc16rfc_crc_byte.sv
src/crc16rfc_frame_track.sv
src/crc16_response_frame_checker.sv
tb/testbench.sv
